/* hw/rtl/double_ended_queue_assert.svh */
// Assertion macros for the double-ended queue.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define DQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("double_ended_queue: assertion failed");
`define DQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("double_ended_queue: assertion failed");
`else
`define DQ_ASSERT(label, clk, rst_n, prop)
`define DQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hw/rtl/dq_pkg.sv */
// Package for the double-ended queue: request and status codes, beat types
// and the command that steers a row of storage cells. Depends on nothing.
package dq_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 12;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [2:0] REQ_PEEK_BACK  = 3'd5;
  localparam logic [2:0] REQ_CLEAR      = 3'd6;
  localparam logic [2:0] REQ_DUMP       = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DATA  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [2:0] MODE_HOLD = 3'd0;
  localparam logic [2:0] MODE_SHR  = 3'd1;
  localparam logic [2:0] MODE_SHL  = 3'd2;
  localparam logic [2:0] MODE_PUT  = 3'd3;
  localparam logic [2:0] MODE_ROT  = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [DATA_W-1:0] value;
  } dq_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] data;
    logic              last;
  } dq_out_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [POS_W-1:0] pos;
  } dq_cmd_t;

endpackage

/* hw/rtl/double_ended_queue.sv */
// Top level of the double-ended queue: two rows of cells, one holding the
// words front to back and one back to front. Depends on dq_pkg and dq_cell.
//
// A request beat is taken at a rising edge with start high and busy low.
// Every request answers with result beats on out_item, each shown for one
// cycle with out_valid high; the receiver cannot hold them off.
// Push, pop, peek and clear answer with one beat in the cycle after the request
// and busy stays low, so a request can be taken every cycle.
// A dump answers with one beat per stored word (one beat if the queue is
// empty), the first in the cycle after the request; busy stays high while
// the remaining beats are produced, set by the front row rotating one place
// per cycle until it is back in its original order.
// A push shifts one row and writes one cell of the other, a pop shifts one row,
// so front and back words are always read from the first cell of a row.
// Reset empties the queue and drops any dump in progress; the stored words
// themselves are not cleared.
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  dq_pkg::dq_in_t   in_item,
  output logic             out_valid,
  output dq_pkg::dq_out_t  out_item
);
  import dq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                   state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  dq_out_t                out_r, out_nxt;

  dq_cmd_t                a_cmd, b_cmd;
  logic [VALUE_WIDTH-1:0] ins_a, ins_b;
  logic [VALUE_WIDTH-1:0] a_q [DEPTH];
  logic [VALUE_WIDTH-1:0] b_q [DEPTH];

  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [VALUE_WIDTH-1:0] push_word;
  logic [POS_W-1:0]       cnt_pos;
  logic [POS_W-1:0]       last_pos;

  assign accept    = start && (state_r == S_IDLE);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign push_word = VALUE_WIDTH'(in_item.value);
  assign cnt_pos   = POS_W'(count_r);
  assign last_pos  = POS_W'(count_r - 1'b1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    logic [VALUE_WIDTH-1:0] a_left, a_right, b_left, b_right;

    if (i == 0) begin : g_first
      assign a_left = ins_a;
      assign b_left = ins_b;
    end else begin : g_mid
      assign a_left = a_q[i-1];
      assign b_left = b_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign a_right = a_q[i];
      assign b_right = b_q[i];
    end else begin : g_inner
      assign a_right = a_q[i+1];
      assign b_right = b_q[i+1];
    end

    dq_cell #(.VALUE_WIDTH(VALUE_WIDTH), .INDEX(i)) u_a_cell (
      .clk     (clk),
      .cmd     (a_cmd),
      .left_i  (a_left),
      .right_i (a_right),
      .ins_i   (ins_a),
      .q_o     (a_q[i])
    );

    dq_cell #(.VALUE_WIDTH(VALUE_WIDTH), .INDEX(i)) u_b_cell (
      .clk     (clk),
      .cmd     (b_cmd),
      .left_i  (b_left),
      .right_i (b_right),
      .ins_i   (ins_b),
      .q_o     (b_q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    a_cmd         = '{mode: MODE_HOLD, pos: '0};
    b_cmd         = '{mode: MODE_HOLD, pos: '0};
    ins_a         = push_word;
    ins_b         = push_word;

    if (state_r == S_DUMP) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{status: ST_DATA, data: DATA_W'(a_q[0]),
                        last: (rem_r == CNT_W'(1))};
      a_cmd         = '{mode: MODE_ROT, pos: last_pos};
      ins_a         = a_q[0];
      rem_nxt       = rem_r - 1'b1;
      if (rem_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{status: ST_OK, data: '0, last: 1'b1};
      case (in_item.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            out_nxt.status = ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
            if (in_item.req_type == REQ_PUSH_FRONT) begin
              a_cmd = '{mode: MODE_SHR, pos: '0};
              b_cmd = '{mode: MODE_PUT, pos: cnt_pos};
            end else begin
              a_cmd = '{mode: MODE_PUT, pos: cnt_pos};
              b_cmd = '{mode: MODE_SHR, pos: '0};
            end
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            out_nxt.status = ST_DATA;
            out_nxt.data   = DATA_W'(a_q[0]);
            if (in_item.req_type == REQ_POP_FRONT) begin
              a_cmd     = '{mode: MODE_SHL, pos: '0};
              count_nxt = count_r - 1'b1;
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (empty) begin
            out_nxt.status = ST_EMPTY;
          end else begin
            out_nxt.status = ST_DATA;
            out_nxt.data   = DATA_W'(b_q[0]);
            if (in_item.req_type == REQ_POP_BACK) begin
              b_cmd     = '{mode: MODE_SHL, pos: '0};
              count_nxt = count_r - 1'b1;
            end
          end
        end
        REQ_CLEAR: begin
          count_nxt = '0;
        end
        REQ_DUMP: begin
          if (!empty) begin
            out_nxt = '{status: ST_DATA, data: DATA_W'(a_q[0]),
                        last: (count_r == CNT_W'(1))};
            a_cmd   = '{mode: MODE_ROT, pos: last_pos};
            ins_a   = a_q[0];
            if (count_r != CNT_W'(1)) begin
              state_nxt = S_DUMP;
              rem_nxt   = count_r - 1'b1;
            end
          end
        end
        default: begin
          out_nxt = '{status: ST_OK, data: '0, last: 1'b1};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy      = (state_r == S_DUMP);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `DQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH))
  `DQ_ASSERT(a_accept_answers, clk, rst_n, accept |=> out_valid)
  `DQ_ASSERT(a_dump_streams, clk, rst_n, busy |=> out_valid && out_item.status == ST_DATA)
  `DQ_ASSERT(a_single_is_last, clk, rst_n, out_valid && out_item.status != ST_DATA |-> out_item.last)
  `DQ_ASSERT(a_dump_count_stable, clk, rst_n, busy |=> $stable(count_r))

endmodule

/* hw/rtl/dq_cell.sv */
// One storage cell of the queue row: holds a word and loads from a neighbour
// or from the broadcast word as the row command says. Depends on dq_pkg.
module dq_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  dq_pkg::dq_cmd_t        cmd,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic [VALUE_WIDTH-1:0] ins_i,
  output logic [VALUE_WIDTH-1:0] q_o
);
  import dq_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

  logic [VALUE_WIDTH-1:0] word_r;
  logic [VALUE_WIDTH-1:0] word_nxt;
  logic                   hit;

  assign hit = (cmd.pos == MY_POS);

  always_comb begin
    case (cmd.mode)
      MODE_SHR: word_nxt = left_i;
      MODE_SHL: word_nxt = right_i;
      MODE_PUT: word_nxt = hit ? ins_i : word_r;
      MODE_ROT: word_nxt = hit ? ins_i : right_i;
      default:  word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q_o = word_r;

endmodule

/* verif/double_ended_queue_tb.sv */
// Self-checking testbench for double_ended_queue: a scoreboard class predicts
// every result beat from the accepted request beats and checks them in order.
// Depends on dq_pkg and the double_ended_queue RTL.
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  localparam int QDEPTH     = 64;
  localparam int IDLE_LIMIT = 500;

  class deque_scoreboard;
    logic [DATA_W-1:0] words [QDEPTH];
    logic [5:0]        front_idx;
    int                word_count;
    dq_out_t           expected_beats[$];
    int                mismatches;

    function new();
      front_idx  = '0;
      word_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void add_beat(logic [1:0] status, logic [DATA_W-1:0] data, logic last);
      dq_out_t beat;
      beat.status = status;
      beat.data   = data;
      beat.last   = last;
      expected_beats = {expected_beats, beat};
    endfunction

    function void note_request(dq_in_t item);
      logic [5:0] slot;
      bit         at_front;
      case (item.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (word_count >= QDEPTH) begin
            add_beat(ST_FULL, '0, 1'b1);
          end else begin
            if (item.req_type == REQ_PUSH_FRONT) begin
              front_idx = front_idx - 6'd1;
              words[front_idx] = item.value;
            end else begin
              slot = front_idx + 6'(word_count);
              words[slot] = item.value;
            end
            word_count++;
            add_beat(ST_OK, '0, 1'b1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (word_count == 0) begin
            add_beat(ST_EMPTY, '0, 1'b1);
          end else begin
            at_front = (item.req_type == REQ_POP_FRONT) || (item.req_type == REQ_PEEK_FRONT);
            slot = at_front ? front_idx : front_idx + 6'(word_count - 1);
            add_beat(ST_DATA, words[slot], 1'b1);
            if (item.req_type == REQ_POP_FRONT) begin
              front_idx = front_idx + 6'd1;
              word_count--;
            end else if (item.req_type == REQ_POP_BACK) begin
              word_count--;
            end
          end
        end
        REQ_CLEAR: begin
          word_count = 0;
          front_idx  = '0;
          add_beat(ST_OK, '0, 1'b1);
        end
        default: begin
          if (word_count == 0) begin
            add_beat(ST_OK, '0, 1'b1);
          end else begin
            for (int i = 0; i < word_count; i++) begin
              slot = front_idx + 6'(i);
              add_beat(ST_DATA, words[slot], i == word_count - 1);
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(dq_out_t got);
      dq_out_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat status %0d data %h last %0b",
                         got.status, got.data, got.last));
        return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.data !== want.data)
        report($sformatf("data %h, expected %h", got.data, want.data));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst_n;
  logic    start;
  logic    busy;
  dq_in_t  req_item;
  logic    out_valid;
  dq_out_t out_item;

  deque_scoreboard board;
  int no_idle_left = 0;
  int idle_cycles  = 0;

  double_ended_queue #(
    .DEPTH(QDEPTH),
    .VALUE_WIDTH(DATA_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(req_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_item);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function int pick_gap();
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      no_idle_left = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  function logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(0, DATA_W - 1);
      default: return $urandom;
    endcase
  endfunction

  task send_request(logic [2:0] req, logic [DATA_W-1:0] value);
    dq_in_t item;
    int     gap;
    item.req_type = req;
    item.value    = value;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    req_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(item);
  endtask

  task wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task push_random_side();
    send_request($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_word());
  endtask

  task run_random(int n);
    int         phase;
    int         push_share;
    int         r;
    logic [2:0] req;
    phase = 2;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        phase = $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
          wait_drained();
      end
      push_share = (phase == 0) ? 70 : (phase == 1) ? 20 : 45;
      r = $urandom_range(0, 99);
      if (r < push_share) begin
        req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
      end else if (r < 94) begin
        case ($urandom_range(0, 5))
          0, 1: req = REQ_POP_FRONT;
          2, 3: req = REQ_POP_BACK;
          4: req = REQ_PEEK_FRONT;
          default: req = REQ_PEEK_BACK;
        endcase
      end else if (r < 99) begin
        req = REQ_DUMP;
      end else begin
        req = REQ_CLEAR;
      end
      send_request(req, rand_word());
    end
  endtask

  initial begin
    board    = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    req_item = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
    send_request(REQ_PEEK_FRONT, 32'h0);
    send_request(REQ_PEEK_BACK, 32'h0);
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_PUSH_BACK, 32'h0000_0000);
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'h8000_0001);
    send_request(REQ_PUSH_FRONT, 32'h7FFF_FFFE);
    send_request(REQ_PEEK_FRONT, 32'h1234_5678);
    send_request(REQ_PEEK_BACK, 32'h0);
    send_request(REQ_DUMP, 32'hFFFF_FFFF);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_CLEAR, 32'hFFFF_FFFF);
    send_request(REQ_DUMP, 32'h0);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    send_request(REQ_PUSH_BACK, 32'h5A5A_5A5A);
    send_request(REQ_POP_BACK, 32'h0);
    send_request(REQ_POP_FRONT, 32'h0);
    send_request(REQ_PEEK_FRONT, 32'h0);
    wait_drained();

    while (board.word_count < QDEPTH) push_random_side();
    repeat (3) push_random_side();
    send_request(REQ_DUMP, rand_word());
    send_request(REQ_PEEK_FRONT, rand_word());
    send_request(REQ_PEEK_BACK, rand_word());
    repeat (20) send_request($urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT, rand_word());
    send_request(REQ_CLEAR, rand_word());
    wait_drained();

    run_random(400);

    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
